// ===== src/fols_pkg.sv =====
// Package: shared types, microprogram table and scaled-multiply helper for the shelving filter.
`default_nettype none

package fols_pkg;

    // Product scaling: shift right by 32, then left by MultK with saturation
    localparam int MultShift = 0;
    localparam int MultK     = MultShift + 1;

    // Datapath widths
    localparam int DataW = 32;
    localparam int ProdW = 2 * DataW;
    localparam int StepW = 3;

    // Multiplier B operand selects
    localparam logic [1:0] BSEL_MEM = 2'd0;
    localparam logic [1:0] BSEL_N   = 2'd1;
    localparam logic [1:0] BSEL_T   = 2'd2;

    // ALU operations
    localparam logic [1:0] ALU_NONE  = 2'd0;
    localparam logic [1:0] ALU_SUB_N = 2'd1;
    localparam logic [1:0] ALU_ADD_T = 2'd2;
    localparam logic [1:0] ALU_OUT_Y = 2'd3;

    // Microprogram step numbers
    localparam logic [StepW-1:0] STEP_IDLE  = 3'd0;
    localparam logic [StepW-1:0] STEP_MUL_A = 3'd1;
    localparam logic [StepW-1:0] STEP_SUB_N = 3'd2;
    localparam logic [StepW-1:0] STEP_MUL_B = 3'd3;
    localparam logic [StepW-1:0] STEP_ADD_T = 3'd4;
    localparam logic [StepW-1:0] STEP_MUL_G = 3'd5;
    localparam logic [StepW-1:0] STEP_OUT_Y = 3'd6;

    // Datapath controls
    typedef struct packed {
        logic       load_x;
        logic       mul_en;
        logic       a_gain;
        logic [1:0] b_sel;
        logic [1:0] alu_op;
    } ctrl_t;

    // One control word of the microprogram
    typedef struct packed {
        ctrl_t ctrl;
        logic  wait_in;
        logic  wait_out;
        logic  last;
    } uword_t;

    // Read-only microprogram
    function automatic uword_t ucode(input logic [StepW-1:0] step);
        uword_t w;
        w = '0;
        w.ctrl.b_sel  = BSEL_MEM;
        w.ctrl.alu_op = ALU_NONE;
        case (step)
            STEP_IDLE: begin
                w.ctrl.load_x = 1'b1;
                w.wait_in     = 1'b1;
            end
            STEP_MUL_A: begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.b_sel  = BSEL_MEM;
            end
            STEP_SUB_N: begin
                w.ctrl.alu_op = ALU_SUB_N;
            end
            STEP_MUL_B: begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.b_sel  = BSEL_N;
            end
            STEP_ADD_T: begin
                w.ctrl.alu_op = ALU_ADD_T;
            end
            STEP_MUL_G: begin
                w.ctrl.mul_en = 1'b1;
                w.ctrl.a_gain = 1'b1;
                w.ctrl.b_sel  = BSEL_T;
            end
            STEP_OUT_Y: begin
                w.ctrl.alu_op = ALU_OUT_Y;
                w.wait_out    = 1'b1;
                w.last        = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Scaled product: high word, shifted left by MultK, saturated
    function automatic logic [DataW-1:0] scale_sat(input logic [ProdW-1:0] p);
        logic [MultK:0]     top;
        logic [DataW-1:0]   hi;
        logic [DataW-1:0]   res;
        top = p[ProdW-1 -: MultK+1];
        hi  = p[ProdW-1:DataW];
        if (top == '0 || top == '1) begin
            res = hi << MultK;
        end else if (p[ProdW-1]) begin
            res = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            res = {1'b0, {(DataW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/fols_datapath.sv =====
// Datapath: shared multiplier, adder and the filter's working registers.
`default_nettype none

module fols_datapath (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire fols_pkg::ctrl_t          ctrl,
    input  wire logic [fols_pkg::DataW-1:0] coeff,
    input  wire logic [fols_pkg::DataW-1:0] gain,
    input  wire logic [fols_pkg::DataW-1:0] sample,
    output logic      [fols_pkg::DataW-1:0] result
);
    import fols_pkg::*;

    logic [DataW-1:0] x_reg;
    logic [DataW-1:0] mem_reg, mem_next;
    logic [DataW-1:0] n_reg, n_next;
    logic [DataW-1:0] t_reg, t_next;
    logic [DataW-1:0] y_reg, y_next;
    logic [ProdW-1:0] prod_reg;
    logic [DataW-1:0] mul_a, mul_b;
    logic [DataW-1:0] scaled;
    logic [DataW-1:0] half;

    // Operand selection for the shared multiplier
    always_comb begin
        mul_a = ctrl.a_gain ? gain : coeff;
        case (ctrl.b_sel)
            BSEL_MEM: mul_b = mem_reg;
            BSEL_N:   mul_b = n_reg;
            BSEL_T:   mul_b = t_reg;
            default:  mul_b = mem_reg;
        endcase
    end

    // Scaled product and its arithmetic half
    assign scaled = scale_sat(prod_reg);
    assign half   = DataW'($signed(scaled) >>> 1);

    // ALU: wrapping adds and a subtract on the scaled product
    always_comb begin
        mem_next = mem_reg;
        n_next   = n_reg;
        t_next   = t_reg;
        y_next   = y_reg;
        case (ctrl.alu_op)
            ALU_SUB_N: begin
                n_next = x_reg - scaled;
            end
            ALU_ADD_T: begin
                t_next   = x_reg + scaled + mem_reg;
                mem_next = n_reg;
            end
            ALU_OUT_Y: begin
                y_next = x_reg + half;
            end
            default: begin
                n_next = n_reg;
            end
        endcase
    end

    // Allpass state word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_reg <= '0;
        end else begin
            mem_reg <= mem_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (ctrl.load_x) begin
            x_reg <= sample;
        end
        if (ctrl.mul_en) begin
            prod_reg <= ProdW'($signed(mul_a) * $signed(mul_b));
        end
        n_reg <= n_next;
        t_reg <= t_next;
        y_reg <= y_next;
    end

    assign result = y_reg;

endmodule

`default_nettype wire

// ===== src/first_order_low_shelving_filter.sv =====
// Top level: first-order low shelving filter with a microcoded sequencer.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[31:0] = sample_in
//  m_       | out | m_tvalid/m_tready  | m_tdata[31:0] = sample_out
//  apb      | in  | psel/penable/pready| 0x0 allpass_coeff, 0x4 shelf_gain
//
// An item passes through one accept step and six microprogram steps, three of
// which share the single 32x32 multiplier. The result sits in an output register,
// so the next item is accepted while it waits. Step six holds while that register
// is still full. Synchronous active-low reset clears the step counter, the output
// valid, the allpass state and both coefficients.
`default_nettype none

module first_order_low_shelving_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] sample_in
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [31:0] sample_out
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import fols_pkg::*;

    logic [StepW-1:0] step_reg, step_next;
    logic             out_valid_reg, out_valid_next;
    logic [DataW-1:0] coeff_reg;
    logic [DataW-1:0] gain_reg;
    uword_t           uw;
    ctrl_t            ctrl;
    logic             go;
    logic             cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
            gain_reg  <= '0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                gain_reg <= pwdata;
            end else begin
                coeff_reg <= pwdata;
            end
        end
    end

    assign prdata = paddr[2] ? gain_reg : coeff_reg;

    // Sequencer: fetch control word, hold on wait conditions
    assign uw = ucode(step_reg);
    assign go = !(uw.wait_in && !s_tvalid) && !(uw.wait_out && out_valid_reg && !m_tready);

    always_comb begin
        ctrl        = uw.ctrl;
        ctrl.load_x = uw.ctrl.load_x && go;
        ctrl.mul_en = uw.ctrl.mul_en && go;
        if (!go) begin
            ctrl.alu_op = ALU_NONE;
        end
    end

    always_comb begin
        if (!go) begin
            step_next = step_reg;
        end else if (uw.last) begin
            step_next = STEP_IDLE;
        end else begin
            step_next = step_reg + 1'b1;
        end
    end

    // Output valid: set on the final step, cleared when the item is taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (go && uw.wait_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = uw.wait_in;
    assign m_tvalid = out_valid_reg;

    fols_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .coeff   (coeff_reg),
        .gain    (gain_reg),
        .sample  (s_tdata),
        .result  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== src/fols_checker.sv =====
// Checker: port-level properties of the shelving filter, bound to the top level.
`default_nettype none

module fols_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The block is busy for the six steps after accepting an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready
            ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input accepted while an item is in work");

    // With the output register empty at accept, a result shows once the microprogram has run its output step
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |-> ##7 m_tvalid)
        else $error("result missing after accept");

endmodule

bind first_order_low_shelving_filter fols_checker u_fols_checker (.*);

`default_nettype wire
